// ===== hdl/sdc_pkg.sv =====
// Package for the SHA-256 digest checker: payload structs, command/status types,
// register indexes, initial hash values and the round-constant table. No dependencies.
package sdc_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic [1:0]  check_status;
    } t_out_item;

    localparam logic [2:0] REG_CHECK_ENABLE = 3'd0;
    localparam logic [2:0] REG_EXPECTED_0   = 3'd1;
    localparam logic [2:0] REG_EXPECTED_1   = 3'd2;
    localparam logic [2:0] REG_EXPECTED_2   = 3'd3;
    localparam logic [2:0] REG_EXPECTED_3   = 3'd4;

    localparam logic [1:0] STATUS_SKIPPED  = 2'd0;
    localparam logic [1:0] STATUS_MATCH    = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH = 2'd2;

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LENGTH_SLOT = 6'd56;

    // Byte-source selects for the buffer write port.
    typedef enum logic [1:0] {
        SRC_DATA   = 2'd0,
        SRC_PAD    = 2'd1,
        SRC_ZERO   = 2'd2,
        SRC_LENGTH = 2'd3
    } t_byte_src;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      buf_write;    // write one byte at the fill pointer, advance it
        t_byte_src buf_src;
        logic      count_inc;    // count one message byte
        logic      load_words;   // start of compression: load working vars
        logic      round;        // one compression round (or schedule load)
        logic      fold;         // add working vars into chain words
        logic      restart;      // back to initial hash, fill and count zero
        logic      emit_shift;   // rotate chain words toward output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [5:0] fill;
        logic       fill_wrap;   // fill pointer is at 63
        logic       last_round;  // round counter is at 63
    } t_status;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/sdc_datapath.sv =====
// Datapath of the SHA-256 digest checker: block buffer (16-word schedule window),
// fill pointer, byte count, chain words and one-round-per-cycle compression. Uses sdc_pkg.
module sdc_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdc_pkg::t_cmd   i_cmd,
    input  logic [7:0]      i_data_byte,
    output sdc_pkg::t_status o_status,
    output logic [31:0]     o_head_word
);

    // The 64-byte block lives as a 16-word sliding window: bytes are written at
    // the fill pointer, and during compression each round shifts out w[t] and
    // appends w[t+16], so the window doubles as the message schedule.
    logic [31:0] r_win [16];
    logic [31:0] n_win [16];
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [5:0]  r_round;
    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];
    logic [7:0]  w_byte;
    logic [63:0] w_bits;
    logic [2:0]  w_len_sel;
    logic [31:0] w_a, w_e, w_t1, w_t2, w_s0, w_s1, w_new;

    assign w_bits    = {r_count, 3'b000};
    assign w_len_sel = r_fill[2:0];

    always_comb begin
        case (i_cmd.buf_src)
            sdc_pkg::SRC_DATA:   w_byte = i_data_byte;
            sdc_pkg::SRC_PAD:    w_byte = sdc_pkg::PAD_BYTE;
            sdc_pkg::SRC_ZERO:   w_byte = 8'h00;
            sdc_pkg::SRC_LENGTH: w_byte = w_bits[6'(6'd56 - {w_len_sel, 3'b000}) +: 8];
            default:             w_byte = 8'h00;
        endcase
    end

    assign w_a  = r_v[0];
    assign w_e  = r_v[4];
    assign w_s0 = {r_win[1][6:0], r_win[1][31:7]} ^ {r_win[1][17:0], r_win[1][31:18]}
                ^ (r_win[1] >> 3);
    assign w_s1 = {r_win[14][16:0], r_win[14][31:17]} ^ {r_win[14][18:0], r_win[14][31:19]}
                ^ (r_win[14] >> 10);
    assign w_new = w_s1 + r_win[9] + w_s0 + r_win[0];
    assign w_t1 = r_v[7] + ({w_e[5:0], w_e[31:6]} ^ {w_e[10:0], w_e[31:11]}
                ^ {w_e[24:0], w_e[31:25]}) + ((w_e & r_v[5]) ^ (~w_e & r_v[6]))
                + sdc_pkg::round_k(r_round) + r_win[0];
    assign w_t2 = ({w_a[1:0], w_a[31:2]} ^ {w_a[12:0], w_a[31:13]} ^ {w_a[21:0], w_a[31:22]})
                + ((w_a & r_v[1]) ^ (w_a & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            n_win[i] = r_win[i];
        end
        if (i_cmd.buf_write) begin
            // Byte lands in word fill/4 at the lane given by fill%4.
            for (int i = 0; i < 16; i++) begin
                if (4'(i) == r_fill[5:2]) begin
                    n_win[i][5'(5'd24 - {r_fill[1:0], 3'b000}) +: 8] = w_byte;
                end
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                n_win[i] = r_win[i + 1];
            end
            n_win[15] = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 16; i++) begin
            r_win[i] <= n_win[i];
        end
        if (i_cmd.load_words) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_chain[i];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= w_t1 + w_t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + w_t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_count <= '0;
            r_round <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= sdc_pkg::INIT_HASH[32*(7-i) +: 32];
            end
        end else begin
            if (i_cmd.buf_write) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.count_inc) begin
                r_count <= r_count + 61'd1;
            end
            if (i_cmd.load_words) begin
                r_round <= '0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.restart) begin
                r_fill  <= '0;
                r_count <= '0;
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= sdc_pkg::INIT_HASH[32*(7-i) +: 32];
                end
            end else if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end else if (i_cmd.emit_shift) begin
                for (int i = 0; i < 7; i++) begin
                    r_chain[i] <= r_chain[i + 1];
                end
                r_chain[7] <= r_chain[0];
            end
        end
    end

    assign o_status.fill       = r_fill;
    assign o_status.fill_wrap  = (r_fill == 6'd63);
    assign o_status.last_round = (r_round == 6'd63);
    assign o_head_word         = r_chain[0];

endmodule

// ===== hdl/sdc_ctrl.sv =====
// Controller of the SHA-256 digest checker: sequences byte loading, padding,
// compression and digest output, and keeps the running check. Uses sdc_pkg.
module sdc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  sdc_pkg::t_in_item i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output sdc_pkg::t_out_item o_out_data,
    input  logic             i_check_enable,
    input  logic [255:0]     i_expected,
    input  sdc_pkg::t_status i_status,
    input  logic [31:0]      i_head_word,
    output sdc_pkg::t_cmd    o_cmd,
    output logic [7:0]       o_data_byte
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,  // writing padding / length bytes
        ST_LOAD  = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_FOLD  = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_WAIT  = 7'b1000000   // byte compression done, back to idle
    } t_state;

    t_state      r_state, n_state;
    logic        r_eom;        // current compression belongs to the end sequence
    logic        r_final;      // current compression is the length block
    logic        r_padded;     // the 0x80 byte has been written
    logic [2:0]  r_idx;
    logic        r_match;
    logic [7:0]  r_byte;
    logic        r_take;       // a byte is pending to be written in idle
    logic        w_accept;
    logic [31:0] w_want;
    logic        w_all_match;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || r_take || r_eom;
    assign o_data_byte = r_byte;
    assign w_want      = i_expected[32*(7-r_idx) +: 32];

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        o_cmd.buf_src = sdc_pkg::SRC_DATA;
        unique case (r_state)
            ST_IDLE: begin
                if (r_take) begin
                    o_cmd.buf_write = 1'b1;
                    o_cmd.count_inc = 1'b1;
                    if (i_status.fill_wrap) begin
                        n_state = ST_LOAD;
                    end else if (r_eom) begin
                        n_state = ST_PAD;
                    end
                end else if (r_eom) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                o_cmd.buf_write = 1'b1;
                if (!r_padded) begin
                    o_cmd.buf_src = sdc_pkg::SRC_PAD;
                end else if (i_status.fill >= sdc_pkg::LENGTH_SLOT && r_final) begin
                    o_cmd.buf_src = sdc_pkg::SRC_LENGTH;
                end else begin
                    o_cmd.buf_src = sdc_pkg::SRC_ZERO;
                end
                if (i_status.fill_wrap) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_words = 1'b1;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_status.last_round) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                if (!r_eom) begin
                    n_state = ST_WAIT;
                end else if (r_final) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_EMIT: begin
                if (!i_out_stall) begin
                    o_cmd.emit_shift = 1'b1;
                    if (r_idx == 3'd7) begin
                        o_cmd.restart = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_WAIT: begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte <= i_in_data.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_eom    <= 1'b0;
            r_final  <= 1'b0;
            r_idx    <= '0;
            r_match  <= 1'b1;
            r_take   <= 1'b0;
            r_padded <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_take <= i_in_data.byte_present;
                r_eom  <= i_in_data.end_of_message;
            end else if (r_state == ST_IDLE && r_take) begin
                r_take <= 1'b0;
            end
            if (r_state == ST_PAD && !r_padded) begin
                r_padded <= 1'b1;
                // Length fits when the 0x80 went at or below byte 55.
                r_final  <= (i_status.fill < sdc_pkg::LENGTH_SLOT);
            end
            // After the first of two padding blocks the next one carries the length.
            if (r_state == ST_FOLD && r_eom && r_padded && !r_final) begin
                r_final <= 1'b1;
            end
            if (r_state == ST_EMIT && !i_out_stall) begin
                if (i_head_word != w_want) begin
                    r_match <= 1'b0;
                end
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_eom    <= 1'b0;
                    r_final  <= 1'b0;
                    r_padded <= 1'b0;
                    r_match  <= 1'b1;
                end
            end
        end
    end

    assign w_all_match = r_match && (i_head_word == w_want);

    always_comb begin
        o_out_valid = (r_state == ST_EMIT);
        o_out_data.digest_word  = i_head_word;
        o_out_data.word_index   = r_idx;
        o_out_data.last_word    = (r_idx == 3'd7);
        o_out_data.check_status = sdc_pkg::STATUS_SKIPPED;
        if (r_idx == 3'd7 && i_check_enable) begin
            o_out_data.check_status = w_all_match ? sdc_pkg::STATUS_MATCH
                                                  : sdc_pkg::STATUS_MISMATCH;
        end
    end

endmodule

// ===== hdl/sha256_digest_check_top.sv =====
// Top level of the SHA-256 digest checker: configuration registers, controller
// and datapath. Uses sdc_pkg, sdc_ctrl and sdc_datapath.
//
// Takes one message byte per transfer and hashes it with SHA-256. Input stalls
// while each byte is written; the item completing a 64-byte block also waits
// for the compression (one round per cycle through a single round unit). The
// end item adds padding writes, one or two compressions and eight output transfers,
// one per digest word, most significant first; the last has the check result.
// The user must write configuration only while idle; it is not enforced.
module sha256_digest_check_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sdc_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sdc_pkg::t_out_item o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    logic             r_check_enable;
    logic [255:0]     r_expected;
    sdc_pkg::t_cmd    w_cmd;
    sdc_pkg::t_status w_status;
    logic [31:0]      w_head;
    logic [7:0]       w_byte;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_enable <= 1'b0;
            r_expected     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sdc_pkg::REG_CHECK_ENABLE: r_check_enable <= i_cfg_data[0];
                sdc_pkg::REG_EXPECTED_0:   r_expected[255:192] <= i_cfg_data;
                sdc_pkg::REG_EXPECTED_1:   r_expected[191:128] <= i_cfg_data;
                sdc_pkg::REG_EXPECTED_2:   r_expected[127:64]  <= i_cfg_data;
                sdc_pkg::REG_EXPECTED_3:   r_expected[63:0]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sdc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_data      (i_in_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data),
        .i_check_enable (r_check_enable),
        .i_expected     (r_expected),
        .i_status       (w_status),
        .i_head_word    (w_head),
        .o_cmd          (w_cmd),
        .o_data_byte    (w_byte)
    );

    sdc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data_byte (w_byte),
        .o_status    (w_status),
        .o_head_word (w_head)
    );

`ifndef SYNTHESIS
    a_no_accept_while_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input taken during digest output");
    a_last_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_word) |-> (o_out_data.word_index == 3'd7))
        else $error("last word flag on wrong index");
    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last_word) |->
        (o_out_data.check_status == sdc_pkg::STATUS_SKIPPED))
        else $error("check status on non-final word");
`endif

endmodule
